[hw/rtl/tbi_pkg.sv]
// ----------------------------------------------------------------------------
// tbi_pkg
// Shared widths, register indexes and sequencer types for the timed Bezier
// interpolator.
// ----------------------------------------------------------------------------
package tbi_pkg;

  // Blend weight format: unsigned Q1.F
  localparam int WEIGHT_FRAC_BITS = 16;
  localparam int F                = WEIGHT_FRAC_BITS;
  localparam int WT_W             = F + 1;            // weight register width
  localparam int MA_W             = 33;               // signed operand A
  localparam int MB_W             = F + 2;            // unsigned operand B (holds 3*aa)
  localparam int PROD_W           = MA_W + MB_W + 1;  // signed product
  localparam int ACC_W            = PROD_W + 2;       // blend accumulator
  localparam int DIV_CNT_W        = $clog2(F + 1);
  localparam int STEP_W           = 4;                // up to ten multiply ops

  // Port widths
  localparam int DT_W       = 16;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_ORDER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_VALUE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_FIRST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_VALUE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FREEZE_MOTION  = 3'd6;

  // Curve order codes (anything else blends as linear)
  localparam logic [1:0] ORDER_LINEAR = 2'd1;
  localparam logic [1:0] ORDER_QUAD   = 2'd2;
  localparam logic [1:0] ORDER_CUBIC  = 2'd3;

  // Where a multiplier result lands
  typedef enum logic [2:0] {
    D_T0, D_T1, D_W0, D_W1, D_W2, D_W3, D_ACC
  } dest_t;

  typedef struct packed {
    logic  go;
    dest_t dest;
  } mul_req_t;

  typedef struct packed {
    logic  vld;
    dest_t dest;
  } mul_rsp_t;

endpackage

[hw/rtl/tbi_mul.sv]
// ----------------------------------------------------------------------------
// tbi_mul
// Shared signed-by-unsigned multiplier with a registered product; carries
// the destination tag of each operation alongside the product.
// ----------------------------------------------------------------------------
module tbi_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tbi_pkg::mul_req_t                  req,
  input  logic signed [tbi_pkg::MA_W-1:0]    op_a,
  input  logic        [tbi_pkg::MB_W-1:0]    op_b,
  output logic signed [tbi_pkg::PROD_W-1:0]  prod_r,
  output tbi_pkg::mul_rsp_t                  rsp
);
  import tbi_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;

  // One product per cycle
  always_comb begin
    prod_nxt = PROD_W'(op_a) * PROD_W'($signed({1'b0, op_b}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp.vld  <= 1'b0;
      rsp.dest <= D_ACC;
    end else begin
      rsp.vld  <= req.go;
      rsp.dest <= req.dest;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (req.go) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

[hw/rtl/timed_bezier_interpolator.sv]
// ----------------------------------------------------------------------------
// timed_bezier_interpolator
// Advances a saturating elapsed-time counter per tick, forms the Q1.F blend
// weight with a restoring divider, and blends start, control and end points
// with linear, quadratic or cubic Bezier weights through one shared
// multiplier.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                    | Direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_ready, in_tick_dt[15:0]       | sink
//  out     | out_valid, out_ready, out_blended_value,   | source
//          | out_done_res                               |
//  cfg     | cfg_we, cfg_index[2:0], cfg_data[31:0]     | write only
//
//  Steps per tick: F divider steps, one weight setup, N multiplier ops
//  (2 linear, 6 quadratic, 10 cubic) on the shared multiplier, one drain,
//  one output load and the idle state that takes the next tick.
//  Ticks that are frozen or arrive after the last result are absorbed in the
//  idle state with no transaction on out.
//  Reset is synchronous, active low; it clears control and configuration state.
//  A stalled output holds; the block waits in the output load step until the
//  output register is free, and accepts the next tick while a result waits.
// ----------------------------------------------------------------------------
module timed_bezier_interpolator (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic        [tbi_pkg::DT_W-1:0]      in_tick_dt,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [tbi_pkg::VAL_W-1:0]     out_blended_value,
  output logic                                 out_done_res,
  input  logic                                 cfg_we,
  input  logic        [tbi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [tbi_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tbi_pkg::*;

  localparam logic [WT_W-1:0]   ONE    = WT_W'(1) << F;
  localparam logic [PROD_W-1:0] HALF_P = PROD_W'(1) << (F - 1);
  localparam logic [ACC_W-1:0]  HALF_A = ACC_W'(1) << (F - 1);
  localparam int                SH_W   = ACC_W - F;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_PREP  = 6'b000100,
    S_MUL   = 6'b001000,
    S_DRAIN = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic        [1:0]       order_r;
  logic signed [VAL_W-1:0] start_r, cf_r, cs_r, end_r;
  logic        [31:0]      dur_r;
  logic                    freeze_r;

  // Run state
  logic [31:0] elapsed_r;
  logic        finished_r;
  logic        full_r, done_r;

  // Divider
  logic [31:0]          rem_r;
  logic [F-1:0]         quo_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  // Weights and accumulator
  logic [WT_W-1:0]         a_r, b_r, t0_r, t1_r;
  logic [WT_W-1:0]         w_r [4];
  logic signed [ACC_W-1:0] acc_r;
  logic [STEP_W-1:0]       step_r;

  // Output register
  logic                    out_valid_r, out_done_r;
  logic signed [VAL_W-1:0] out_val_r;

  // ---- configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= ORDER_LINEAR;
      start_r  <= '0;
      cf_r     <= '0;
      cs_r     <= '0;
      end_r    <= '0;
      dur_r    <= '0;
      freeze_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CURVE_ORDER:    order_r  <= cfg_data[1:0];
        REG_START_VALUE:    start_r  <= $signed(cfg_data);
        REG_CONTROL_FIRST:  cf_r     <= $signed(cfg_data);
        REG_CONTROL_SECOND: cs_r     <= $signed(cfg_data);
        REG_END_VALUE:      end_r    <= $signed(cfg_data);
        REG_DURATION:       dur_r    <= cfg_data;
        REG_FREEZE_MOTION:  freeze_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---- tick acceptance and elapsed time update
  logic        accept, run;
  logic [32:0] sum;
  logic [31:0] elapsed_new;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign run         = accept && !freeze_r && !finished_r;
  assign sum         = {1'b0, elapsed_r} + 33'(in_tick_dt);
  assign elapsed_new = sum[32] ? '1 : sum[31:0];

  // ---- restoring divider step: (elapsed << F) / duration
  logic [32:0] rem2;
  logic [33:0] diff;
  logic        ge;

  assign rem2 = {rem_r, 1'b0};
  assign diff = {1'b0, rem2} - {2'b00, dur_r};
  assign ge   = !diff[33];

  // ---- operand selection for the current multiplier op
  mul_req_t                 req;
  mul_rsp_t                 rsp;
  logic signed [MA_W-1:0]   op_a;
  logic        [MB_W-1:0]   op_b;
  logic signed [PROD_W-1:0] prod_r;
  logic                     op_last;
  logic signed [MA_W-1:0]   a_ext, b_ext;

  assign a_ext = $signed(MA_W'(a_r));
  assign b_ext = $signed(MA_W'(b_r));

  always_comb begin
    op_a     = a_ext;
    op_b     = MB_W'(a_r);
    req.go   = (state_r == S_MUL);
    req.dest = D_ACC;
    op_last  = 1'b0;
    case (order_r)
      ORDER_QUAD: begin
        case (step_r)
          4'd0: begin op_b = MB_W'(a_r); req.dest = D_W0; end
          4'd1: begin op_b = MB_W'(b_r) << 1; req.dest = D_W1; end
          4'd2: begin op_a = b_ext; op_b = MB_W'(b_r); req.dest = D_W2; end
          4'd3: begin op_a = MA_W'(start_r); op_b = MB_W'(w_r[0]); end
          4'd4: begin op_a = MA_W'(cf_r); op_b = MB_W'(w_r[1]); end
          default: begin
            op_a = MA_W'(end_r); op_b = MB_W'(w_r[2]); op_last = 1'b1;
          end
        endcase
      end
      ORDER_CUBIC: begin
        case (step_r)
          4'd0: begin op_b = MB_W'(a_r); req.dest = D_T0; end
          4'd1: begin op_a = b_ext; op_b = MB_W'(b_r); req.dest = D_T1; end
          4'd2: begin op_b = MB_W'(t0_r); req.dest = D_W0; end
          4'd3: begin
            op_a = b_ext; op_b = (MB_W'(t0_r) << 1) + MB_W'(t0_r); req.dest = D_W1;
          end
          4'd4: begin op_b = (MB_W'(t1_r) << 1) + MB_W'(t1_r); req.dest = D_W2; end
          4'd5: begin op_a = b_ext; op_b = MB_W'(t1_r); req.dest = D_W3; end
          4'd6: begin op_a = MA_W'(start_r); op_b = MB_W'(w_r[0]); end
          4'd7: begin op_a = MA_W'(cf_r); op_b = MB_W'(w_r[1]); end
          4'd8: begin op_a = MA_W'(cs_r); op_b = MB_W'(w_r[2]); end
          default: begin
            op_a = MA_W'(end_r); op_b = MB_W'(w_r[3]); op_last = 1'b1;
          end
        endcase
      end
      default: begin
        // linear, also for order zero
        if (step_r == '0) begin
          op_a = MA_W'(start_r); op_b = MB_W'(a_r);
        end else begin
          op_a = MA_W'(end_r); op_b = MB_W'(b_r); op_last = 1'b1;
        end
      end
    endcase
  end

  tbi_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r),
    .rsp    (rsp)
  );

  // ---- product writeback: rounded weight or accumulate
  logic [PROD_W-1:0] prod_rnd;
  logic [WT_W-1:0]   wt_new;

  assign prod_rnd = $unsigned(prod_r) + HALF_P;
  assign wt_new   = prod_rnd[F +: WT_W];

  // ---- final rounding and saturation
  logic [ACC_W-1:0]       acc_rnd;
  logic signed [SH_W-1:0] shifted;
  logic signed [VAL_W-1:0] sat_val;
  logic                   fits;

  assign acc_rnd = $unsigned(acc_r) + HALF_A;
  assign shifted = $signed(acc_rnd[ACC_W-1:F]);
  assign fits    = (&shifted[SH_W-1:VAL_W-1]) || !(|shifted[SH_W-1:VAL_W-1]);

  always_comb begin
    if (fits) begin
      sat_val = shifted[VAL_W-1:0];
    end else if (shifted[SH_W-1]) begin
      sat_val = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  // ---- sequencer
  logic [WT_W-1:0] b_val;
  logic            out_load;

  assign b_val    = full_r ? ONE : {1'b0, quo_r};
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (run) state_nxt = S_DIV;
      S_DIV:   if (div_cnt_r == DIV_CNT_W'(F - 1)) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_MUL;
      S_MUL:   if (op_last) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_FIN;
      S_FIN:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      elapsed_r   <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
      step_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (run) begin
        elapsed_r  <= elapsed_new;
        finished_r <= (elapsed_new > dur_r);
        div_cnt_r  <= '0;
      end
      if (state_r == S_DIV) begin
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      if (state_r == S_PREP) begin
        step_r <= '0;
      end else if (state_r == S_MUL) begin
        step_r <= step_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk) begin
    if (run) begin
      rem_r  <= elapsed_new;
      full_r <= (dur_r == '0) || (elapsed_new >= dur_r);
      done_r <= (elapsed_new > dur_r);
    end
    if (state_r == S_DIV) begin
      rem_r <= ge ? diff[31:0] : rem2[31:0];
      quo_r <= {quo_r[F-2:0], ge};
    end
    if (state_r == S_PREP) begin
      b_r   <= b_val;
      a_r   <= ONE - b_val;
      acc_r <= '0;
    end
    if (rsp.vld) begin
      case (rsp.dest)
        D_T0:    t0_r   <= wt_new;
        D_T1:    t1_r   <= wt_new;
        D_W0:    w_r[0] <= wt_new;
        D_W1:    w_r[1] <= wt_new;
        D_W2:    w_r[2] <= wt_new;
        D_W3:    w_r[3] <= wt_new;
        D_ACC:   acc_r  <= acc_r + ACC_W'(prod_r);
        default: ;
      endcase
    end
    if (out_load) begin
      out_val_r  <= sat_val;
      out_done_r <= done_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_blended_value = out_val_r;
  assign out_done_res      = out_done_r;

endmodule

[hw/rtl/tbi_checker.sv]
// ----------------------------------------------------------------------------
// tbi_checker
// Port-level assertions for the timed Bezier interpolator, bound to the top.
// ----------------------------------------------------------------------------
module tbi_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [tbi_pkg::VAL_W-1:0]     out_blended_value,
  input logic                                 out_done_res
);
  import tbi_pkg::*;

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_blended_value)
                                && $stable(out_done_res))
    else $error("result changed while stalled");

  // The input side only goes busy after taking a tick
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid))
    else $error("input went busy without a transaction");

  // A new result is loaded only while the input side is busy
  a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a computation");

  // Nothing follows the last result
  a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_done_res |=> !out_valid)
    else $error("result after the last one");

endmodule

bind timed_bezier_interpolator tbi_checker u_tbi_checker (.*);

[test/timed_bezier_interpolator_checker.sv]
// ----------------------------------------------------------------------------
// timed_bezier_interpolator_checker
// Watches the tick, result and register-write ports of the timed Bezier
// interpolator. It keeps its own copy of the registers, the elapsed-time
// counter and the finished flag, predicts the blended value and done flag of
// every accepted tick that is not frozen or finished, and compares them in
// order with the results that leave the block.
// ----------------------------------------------------------------------------
module timed_bezier_interpolator_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic        [tbi_pkg::DT_W-1:0]      in_tick_dt,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [tbi_pkg::VAL_W-1:0]     out_blended_value,
  input  logic                                 out_done_res,
  input  logic                                 cfg_we,
  input  logic        [tbi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [tbi_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                   fail_count,
  output int                                   pending_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import tbi_pkg::*;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    done;
  } blend_sample_t;

  // Results still owed by the block, oldest first
  blend_sample_t blends_due_q[$];

  // Shadow registers and state
  logic [1:0]              order_sh;
  logic signed [VAL_W-1:0] start_sh;
  logic signed [VAL_W-1:0] ctrl1_sh;
  logic signed [VAL_W-1:0] ctrl2_sh;
  logic signed [VAL_W-1:0] end_sh;
  logic [31:0]             duration_sh;
  logic                    freeze_sh;
  logic [31:0]             elapsed_sh;
  logic                    finished_sh;

  // Round half up, drop the weight fraction
  function automatic longint unsigned round_weight(longint unsigned x);
    return (x + (64'd1 << (WEIGHT_FRAC_BITS - 1))) >> WEIGHT_FRAC_BITS;
  endfunction

  // Blended value at elapsed time t with the current registers
  function automatic logic signed [VAL_W-1:0] bezier_at(logic [31:0] t);
    longint unsigned one, b, a, aa, bb;
    longint          acc;
    one = 64'd1 << WEIGHT_FRAC_BITS;
    if (duration_sh == 32'd0 || t >= duration_sh) begin
      b = one;
    end else begin
      b = ({32'd0, t} << WEIGHT_FRAC_BITS) / {32'd0, duration_sh};
    end
    a = one - b;
    case (order_sh)
      ORDER_QUAD: begin
        acc = start_sh * longint'(round_weight(a * a))
            + ctrl1_sh * longint'(round_weight(64'd2 * a * b))
            + end_sh   * longint'(round_weight(b * b));
      end
      ORDER_CUBIC: begin
        aa  = round_weight(a * a);
        bb  = round_weight(b * b);
        acc = start_sh * longint'(round_weight(aa * a))
            + ctrl1_sh * longint'(round_weight(64'd3 * aa * b))
            + ctrl2_sh * longint'(round_weight(64'd3 * a * bb))
            + end_sh   * longint'(round_weight(bb * b));
      end
      // order 0 falls back to linear
      default: begin
        acc = start_sh * longint'(a) + end_sh * longint'(b);
      end
    endcase
    acc = (acc + (longint'(1) << (WEIGHT_FRAC_BITS - 1))) >>> WEIGHT_FRAC_BITS;
    if (acc > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (acc < -64'sd2147483648) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  always @(posedge clk) begin
    blend_sample_t due;
    logic [32:0]   sum;
    if (!rst_n) begin
      order_sh      = ORDER_LINEAR;
      start_sh      = '0;
      ctrl1_sh      = '0;
      ctrl2_sh      = '0;
      end_sh        = '0;
      duration_sh   = '0;
      freeze_sh     = 1'b0;
      elapsed_sh    = '0;
      finished_sh   = 1'b0;
      blends_due_q.delete();
      fail_count    = 0;
      pending_count = 0;
    end else begin
      // Result transaction: compare with the oldest prediction
      if (out_valid && out_ready) begin
        if (blends_due_q.size() == 0) begin
          $error("unexpected result: blended_value %0d done_res %0b",
                 out_blended_value, out_done_res);
          fail_count = fail_count + 1;
        end else begin
          due = blends_due_q.pop_front();
          if (out_blended_value !== due.value) begin
            $error("blended_value mismatch: expected %0d, actual %0d",
                   $signed(due.value), out_blended_value);
            fail_count = fail_count + 1;
          end
          if (out_done_res !== due.done) begin
            $error("done_res mismatch: expected %0b, actual %0b",
                   due.done, out_done_res);
            fail_count = fail_count + 1;
          end
        end
      end

      // Tick transaction: frozen or finished ticks give nothing
      if (in_valid && in_ready && !freeze_sh && !finished_sh) begin
        sum        = {1'b0, elapsed_sh} + 33'(in_tick_dt);
        elapsed_sh = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        due.value  = bezier_at(elapsed_sh);
        due.done   = elapsed_sh > duration_sh;
        if (due.done) finished_sh = 1'b1;
        blends_due_q = {blends_due_q, due};
      end

      // Register writes take effect after this edge
      if (cfg_we) begin
        case (cfg_index)
          REG_CURVE_ORDER:    order_sh    = cfg_data[1:0];
          REG_START_VALUE:    start_sh    = cfg_data;
          REG_CONTROL_FIRST:  ctrl1_sh    = cfg_data;
          REG_CONTROL_SECOND: ctrl2_sh    = cfg_data;
          REG_END_VALUE:      end_sh      = cfg_data;
          REG_DURATION:       duration_sh = cfg_data;
          REG_FREEZE_MOTION:  freeze_sh   = cfg_data[0];
          default: ;
        endcase
      end

      pending_count = blends_due_q.size();
    end
  end

endmodule

[test/timed_bezier_interpolator_tb.sv]
// ----------------------------------------------------------------------------
// timed_bezier_interpolator_tb
// Drives ticks and register writes into the timed Bezier interpolator: a
// short directed opening (zero duration, freeze, every curve order, extreme
// points), random curve settings with random tick sizes, then an unthrottled
// stretch on the longest duration and a zero-duration finish. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module timed_bezier_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tbi_pkg::*;

  localparam logic [31:0] DUR_MAX           = 32'hFFFF_FFFF;
  localparam logic [31:0] Q_MAX             = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN             = 32'h8000_0000;
  localparam int          SETTLE_CYC        = 40;
  localparam int          RANDOM_TICKS      = 760;
  localparam int          UNTHROTTLED_TICKS = 40;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_valid   = 1'b0;
  logic [DT_W-1:0]         in_tick_dt = '0;
  logic                    out_ready  = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = '0;
  logic [CFG_DATA_W-1:0]   cfg_data   = '0;
  logic                    in_ready;
  logic                    out_valid;
  logic signed [VAL_W-1:0] out_blended_value;
  logic                    out_done_res;
  int                      fail_count;
  int                      pending_count;

  // Stimulus bookkeeping
  bit          stall_on     = 1'b0;
  bit          gaps_on      = 1'b0;
  int          stall_left   = 0;
  logic [31:0] elapsed_now  = '0;
  bit          frozen_now   = 1'b0;
  int          ticks_counted = 0;

  always #5 clk = ~clk;

  timed_bezier_interpolator u_dut (.*);

  timed_bezier_interpolator_checker u_checker (.*);

  // Result side backpressure in bursts of random length while stall_on is set
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Called right after a rising edge; returns right after the write edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Wait for the block to drain, then rewrite every register
  task automatic load_curve(input logic [1:0] order, input logic [31:0] p0,
                            input logic [31:0] p1, input logic [31:0] p2,
                            input logic [31:0] p3, input logic [31:0] dur,
                            input logic freeze);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    // ignored ticks may still be in flight
    repeat (SETTLE_CYC) @(posedge clk);
    write_reg(REG_CURVE_ORDER, {30'd0, order});
    write_reg(REG_START_VALUE, p0);
    write_reg(REG_CONTROL_FIRST, p1);
    write_reg(REG_CONTROL_SECOND, p2);
    write_reg(REG_END_VALUE, p3);
    write_reg(REG_DURATION, dur);
    write_reg(REG_FREEZE_MOTION, {31'd0, freeze});
    cfg_we     <= 1'b0;
    frozen_now = freeze;
  endtask

  // One tick transaction, with an optional idle gap in front
  task automatic send_tick(input logic [DT_W-1:0] dt);
    bit          ok;
    int          gap;
    logic [32:0] sum;
    gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_tick_dt <= dt;
    // ready is stable between the falling edge and the next rising edge
    do begin
      @(negedge clk);
      ok = in_ready;
      @(posedge clk);
    end while (!ok);
    if (!frozen_now) begin
      sum           = {1'b0, elapsed_now} + 33'(dt);
      elapsed_now   = sum[32] ? DUR_MAX : sum[31:0];
      ticks_counted = ticks_counted + 1;
    end
  endtask

  // Control point: mostly extremes and small values, some full range
  function automatic logic [31:0] pick_point();
    case ($urandom_range(0, 7))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 32'd0;
      3: return $urandom_range(0, 32'h0004_0000);
      4: return 32'(-int'($urandom_range(0, 32'h0004_0000)));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [1:0]  order;
    logic [31:0] dur;
    int          nticks;
    int          max_dt;
    int          span;

    repeat (8) @(posedge clk);
    rst_n    <= 1'b1;
    stall_on = 1'b1;
    gaps_on  = 1'b1;

    // Reset values: zero duration, zero step, all points zero
    send_tick(16'h0000);

    // Zero duration before any time has passed: end value, not done
    load_curve(ORDER_CUBIC, 32'h0001_0000, Q_MAX, Q_MIN, 32'hFFFD_8000, 32'd0, 1'b0);
    send_tick(16'h0000);

    // Frozen: ticks swallowed, time stands still
    load_curve(ORDER_CUBIC, 32'h0001_0000, Q_MAX, Q_MIN, 32'hFFFD_8000, 32'd0, 1'b1);
    send_tick(16'hFFFF);
    send_tick(16'hAAAA);

    // Order zero blends as linear; longest duration
    load_curve(2'd0, Q_MIN, 32'd0, 32'd0, Q_MAX, DUR_MAX, 1'b0);
    send_tick(16'hFFFF);
    send_tick(16'h5555);
    send_tick(16'h0001);
    send_tick(16'h0000);

    // Quadratic at full scale, running up to exactly the duration
    load_curve(ORDER_QUAD, Q_MAX, Q_MAX, Q_MAX, Q_MAX, elapsed_now + 4 * 65535, 1'b0);
    repeat (4) send_tick(16'hFFFF);

    // Cubic at negative full scale
    load_curve(ORDER_CUBIC, Q_MIN, Q_MIN, Q_MIN, Q_MIN, elapsed_now + 200000, 1'b0);
    send_tick(16'h8000);
    send_tick(16'h7FFF);
    send_tick(16'hFFFF);

    // Linear in thirds of a tiny duration
    load_curve(ORDER_LINEAR, Q_MAX, 32'd0, 32'd0, Q_MIN, elapsed_now + 3, 1'b0);
    repeat (3) send_tick(16'h0001);

    // Random curves; the duration always stays ahead of the time budget
    ticks_counted = 0;
    while (ticks_counted < RANDOM_TICKS) begin
      nticks = $urandom_range(10, 40);
      case ($urandom_range(0, 2))
        0:       max_dt = 65535;
        1:       max_dt = $urandom_range(1, 65535);
        default: max_dt = 15;
      endcase
      span = nticks * max_dt;
      case ($urandom_range(0, 3))
        0:       dur = DUR_MAX;
        1:       dur = elapsed_now + span;
        2:       dur = elapsed_now + span + $urandom_range(0, 4 * span);
        default: dur = elapsed_now + span + $urandom_range(0, 255);
      endcase
      order    = 2'($urandom_range(0, 3));
      stall_on = ($urandom_range(0, 3) != 0);
      gaps_on  = ($urandom_range(0, 3) != 0);
      load_curve(order, pick_point(), pick_point(), pick_point(), pick_point(), dur,
                 $urandom_range(0, 7) == 0);
      repeat (nticks) send_tick(DT_W'($urandom_range(0, max_dt)));
    end

    // No idling from here on: back-to-back ticks on the longest duration
    stall_on = 1'b0;
    gaps_on  = 1'b0;
    load_curve(ORDER_LINEAR, pick_point(), 32'd0, 32'd0, pick_point(), DUR_MAX, 1'b0);
    repeat (UNTHROTTLED_TICKS) send_tick(DT_W'($urandom_range(0, 65535)));

    // Zero duration with time passed: last result, then silence
    load_curve(ORDER_CUBIC, pick_point(), pick_point(), pick_point(), pick_point(),
               32'd0, 1'b0);
    send_tick(16'h0000);
    send_tick(16'hFFFF);
    send_tick(16'h0000);

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[timed_bezier_interpolator] OK");
    end else begin
      $display("[timed_bezier_interpolator] ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #10_000_000;
    $display("[timed_bezier_interpolator] ERROR");
    $finish;
  end

endmodule
